/* rtl/pwn_pkg.sv */
// Package for the pulse width normalizer: widths, register indexes,
// reset values and the struct types shared between the pipeline modules.
// No dependencies.
`default_nettype none

package pwn_pkg;

    // Field widths fixed by the interface
    localparam int PWM_W     = 16;
    localparam int CMD_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // Default number of fraction bits of the command
    localparam int FRACTION_BITS = 15;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_WIDTH     = 3'd0,
        REG_MAX_WIDTH     = 3'd1,
        REG_TRIM_WIDTH    = 3'd2,
        REG_THROTTLE_MODE = 3'd3,
        REG_REVERSE       = 3'd4
    } pwn_reg_t;

    // Register reset values
    localparam logic [PWM_W-1:0] MIN_WIDTH_RST  = 16'd1000;
    localparam logic [PWM_W-1:0] MAX_WIDTH_RST  = 16'd2000;
    localparam logic [PWM_W-1:0] TRIM_WIDTH_RST = 16'd1500;

    // Live configuration
    typedef struct packed {
        logic [PWM_W-1:0] min_width;
        logic [PWM_W-1:0] max_width;
        logic [PWM_W-1:0] trim_width;
        logic             throttle_mode;
        logic             reverse;
    } pwn_cfg_t;

    // Per-word control flags that travel down the pipeline
    typedef struct packed {
        logic throttle;  // unipolar mapping from minimum
        logic rev;       // invert direction
        logic neg;       // width below trim in centered mode
        logic zero;      // span zero or negative: command 0
        logic sat;       // magnitude at or above span: full scale
    } pwn_flags_t;

endpackage

`default_nettype wire

/* rtl/pwn_cfg_regs.sv */
// Configuration register file of the pulse width normalizer.
// Depends on pwn_pkg for register indexes, reset values and pwn_cfg_t.
`default_nettype none

module pwn_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pwn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pwn_pkg::CFG_W-1:0]      cfg_data,
    output pwn_pkg::pwn_cfg_t                   cfg
);
    import pwn_pkg::*;

    pwn_cfg_t cfg_reg;
    pwn_cfg_t cfg_next;

    // Always take a write
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index; unknown indexes drop the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (pwn_reg_t'(cfg_index))
                REG_MIN_WIDTH:     cfg_next.min_width     = cfg_data[PWM_W-1:0];
                REG_MAX_WIDTH:     cfg_next.max_width     = cfg_data[PWM_W-1:0];
                REG_TRIM_WIDTH:    cfg_next.trim_width    = cfg_data[PWM_W-1:0];
                REG_THROTTLE_MODE: cfg_next.throttle_mode = cfg_data[0];
                REG_REVERSE:       cfg_next.reverse       = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_width     <= MIN_WIDTH_RST;
            cfg_reg.max_width     <= MAX_WIDTH_RST;
            cfg_reg.trim_width    <= TRIM_WIDTH_RST;
            cfg_reg.throttle_mode <= 1'b0;
            cfg_reg.reverse       <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/pwn_front.sv */
// Front end of the normalizer: clamp, span selection and dividend setup,
// three register stages. Depends on pwn_pkg for pwn_cfg_t and pwn_flags_t.
`default_nettype none

module pwn_front #(
    parameter int FRAC_BITS = pwn_pkg::FRACTION_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [pwn_pkg::PWM_W-1:0]   in_width,
    input  wire pwn_pkg::pwn_cfg_t           cfg,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [pwn_pkg::PWM_W-1:0]        out_rem,
    output logic [FRAC_BITS-1:0]             out_low,
    output logic [pwn_pkg::PWM_W-1:0]        out_den,
    output pwn_pkg::pwn_flags_t              out_flags
);
    import pwn_pkg::*;

    localparam int NW = PWM_W + FRAC_BITS;

    // Stage 1: clamped width and configuration snapshot
    logic             s1_valid_reg;
    logic [PWM_W-1:0] s1_width_reg;
    pwn_cfg_t         s1_cfg_reg;
    logic             s1_ready;
    logic [PWM_W-1:0] w_lo;
    logic [PWM_W-1:0] w_clamp;

    // Stage 2: magnitude of the distance and signed span
    logic             s2_valid_reg;
    logic [PWM_W-1:0] s2_mag_reg;
    logic [PWM_W:0]   s2_den_reg;
    pwn_flags_t       s2_flags_reg;
    logic             s2_ready;
    logic             below_trim;
    logic [PWM_W-1:0] mag_next;
    logic [PWM_W:0]   den_next;
    pwn_flags_t       flags2_next;

    // Stage 3: dividend mag * full scale and special-case flags
    logic             s3_valid_reg;
    logic [PWM_W-1:0] s3_rem_reg;
    logic [FRAC_BITS-1:0] s3_low_reg;
    logic [PWM_W-1:0] s3_den_reg;
    pwn_flags_t       s3_flags_reg;
    logic             s3_ready;
    logic [NW-1:0]    prod;
    pwn_flags_t       flags3_next;

    // Ready chain: a stage takes a word when empty or draining
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Clamp to minimum first, then to maximum so maximum wins
    always_comb
    begin
        w_lo    = (in_width < cfg.min_width) ? cfg.min_width : in_width;
        w_clamp = (w_lo > cfg.max_width) ? cfg.max_width : w_lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_width_reg <= w_clamp;
            s1_cfg_reg   <= cfg;
        end
    end

    // Pick distance and span for the mode
    always_comb
    begin
        below_trim = s1_width_reg < s1_cfg_reg.trim_width;
        if (s1_cfg_reg.throttle_mode)
        begin
            mag_next = s1_width_reg - s1_cfg_reg.min_width;
            den_next = {1'b0, s1_cfg_reg.max_width} - {1'b0, s1_cfg_reg.min_width};
        end
        else if (below_trim)
        begin
            mag_next = s1_cfg_reg.trim_width - s1_width_reg;
            den_next = {1'b0, s1_cfg_reg.trim_width} - {1'b0, s1_cfg_reg.min_width};
        end
        else
        begin
            mag_next = s1_width_reg - s1_cfg_reg.trim_width;
            den_next = {1'b0, s1_cfg_reg.max_width} - {1'b0, s1_cfg_reg.trim_width};
        end
        flags2_next.throttle = s1_cfg_reg.throttle_mode;
        flags2_next.rev      = s1_cfg_reg.reverse;
        flags2_next.neg      = !s1_cfg_reg.throttle_mode && below_trim;
        flags2_next.zero     = 1'b0;
        flags2_next.sat      = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_mag_reg   <= mag_next;
            s2_den_reg   <= den_next;
            s2_flags_reg <= flags2_next;
        end
    end

    // Form mag * (2^F - 1) as a shift and subtract; flag the special cases
    always_comb
    begin
        prod              = {s2_mag_reg, {FRAC_BITS{1'b0}}} - NW'(s2_mag_reg);
        flags3_next       = s2_flags_reg;
        flags3_next.zero  = s2_den_reg[PWM_W] || (s2_den_reg == '0);
        flags3_next.sat   = {1'b0, s2_mag_reg} >= s2_den_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_rem_reg   <= prod[NW-1:FRAC_BITS];
            s3_low_reg   <= prod[FRAC_BITS-1:0];
            s3_den_reg   <= s2_den_reg[PWM_W-1:0];
            s3_flags_reg <= flags3_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_rem   = s3_rem_reg;
    assign out_low   = s3_low_reg;
    assign out_den   = s3_den_reg;
    assign out_flags = s3_flags_reg;

endmodule

`default_nettype wire

/* rtl/pwn_div_step.sv */
// One restoring division step: one quotient bit per register stage.
// Depends on pwn_pkg for pwn_flags_t.
`default_nettype none

module pwn_div_step #(
    parameter int FRAC_BITS = pwn_pkg::FRACTION_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [pwn_pkg::PWM_W-1:0]   in_rem,
    input  wire logic [FRAC_BITS-1:0]        in_low,
    input  wire logic [pwn_pkg::PWM_W-1:0]   in_den,
    input  wire pwn_pkg::pwn_flags_t         in_flags,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [pwn_pkg::PWM_W-1:0]        out_rem,
    output logic [FRAC_BITS-1:0]             out_low,
    output logic [pwn_pkg::PWM_W-1:0]        out_den,
    output pwn_pkg::pwn_flags_t              out_flags
);
    import pwn_pkg::*;

    logic                 valid_reg;
    logic [PWM_W-1:0]     rem_reg;
    logic [FRAC_BITS-1:0] low_reg;
    logic [PWM_W-1:0]     den_reg;
    pwn_flags_t           flags_reg;

    logic [PWM_W:0]       trial;
    logic [PWM_W:0]       diff;
    logic                 fits;
    logic [PWM_W-1:0]     rem_next;
    logic [FRAC_BITS-1:0] low_next;

    assign in_ready = !valid_reg || out_ready;

    // Shift in the next dividend bit, subtract the divisor if it fits
    always_comb
    begin
        trial    = {in_rem, in_low[FRAC_BITS-1]};
        diff     = trial - {1'b0, in_den};
        fits     = trial >= {1'b0, in_den};
        rem_next = fits ? diff[PWM_W-1:0] : trial[PWM_W-1:0];
        low_next = {in_low[FRAC_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg   <= rem_next;
            low_reg   <= low_next;
            den_reg   <= in_den;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_low   = low_reg;
    assign out_den   = den_reg;
    assign out_flags = flags_reg;

endmodule

`default_nettype wire

/* rtl/pwn_out.sv */
// Output stage: special cases, direction and reverse, output register.
// Depends on pwn_pkg for pwn_flags_t and the command width.
`default_nettype none

module pwn_out #(
    parameter int FRAC_BITS = pwn_pkg::FRACTION_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [FRAC_BITS-1:0]        in_quot,
    input  wire pwn_pkg::pwn_flags_t         in_flags,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [pwn_pkg::CMD_W-1:0]        out_cmd
);
    import pwn_pkg::*;

    // Working width: the full signed range, at least the command width
    localparam int CW = (FRAC_BITS + 2 > CMD_W) ? FRAC_BITS + 2 : CMD_W;

    logic             valid_reg;
    logic [CMD_W-1:0] cmd_reg;
    logic [CW-1:0]    full_scale;
    logic [CW-1:0]    mag;
    logic [CW-1:0]    cmd_next;

    assign in_ready = !valid_reg || out_ready;

    // Apply zero span and saturation, then mode and reverse
    always_comb
    begin
        full_scale = CW'({FRAC_BITS{1'b1}});
        if (in_flags.zero)
        begin
            mag = '0;
        end
        else if (in_flags.sat)
        begin
            mag = full_scale;
        end
        else
        begin
            mag = CW'(in_quot);
        end
        if (in_flags.throttle)
        begin
            cmd_next = in_flags.rev ? (full_scale - mag) : mag;
        end
        else
        begin
            cmd_next = (in_flags.neg ^ in_flags.rev) ? (CW'(0) - mag) : mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg <= cmd_next[CMD_W-1:0];
        end
    end

    assign out_valid = valid_reg;
    assign out_cmd   = cmd_reg;

endmodule

`default_nettype wire

/* rtl/pwm_pulse_width_normalizer_top.sv */
// Top level of the RC pulse width normalizer: register file, front end,
// divider pipeline and output stage. Depends on pwn_pkg and all pwn_ modules.
//
//  channel  dir  handshake              payload
//  s_       in   s_tvalid / s_tready    s_tdata[15:0]  pulse_width
//  m_       out  m_tvalid / m_tready    m_tdata[15:0]  command (signed)
//  cfg_     in   cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[15:0]
//
// The pipeline has three front stages, one restoring divider stage per
// quotient bit and one output stage.
// One word is accepted per cycle unless m_ stalls; the divider chain sets the depth.
// Reset empties the pipeline and loads register defaults; no clearing pass.
// A stall at m_ holds each full stage with no empty stage ahead; others still advance from s_.
`default_nettype none

module pwm_pulse_width_normalizer_top #(
    parameter int FRAC_BITS = pwn_pkg::FRACTION_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // pulse_width
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pwn_pkg::PWM_W-1:0]      s_tdata,    // [15:0] pulse_width
    // command
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [pwn_pkg::CMD_W-1:0]           m_tdata,    // [15:0] command, signed
    // register writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pwn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pwn_pkg::CFG_W-1:0]      cfg_data
);
    import pwn_pkg::*;

    pwn_cfg_t cfg;

    // Divider chain taps: index 0 is the front end output
    logic                 dv_valid [0:FRAC_BITS];
    logic                 dv_ready [0:FRAC_BITS];
    logic [PWM_W-1:0]     dv_rem   [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] dv_low   [0:FRAC_BITS];
    logic [PWM_W-1:0]     dv_den   [0:FRAC_BITS];
    pwn_flags_t           dv_flags [0:FRAC_BITS];

    pwn_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pwn_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_width  (s_tdata),
        .cfg       (cfg),
        .out_valid (dv_valid[0]),
        .out_ready (dv_ready[0]),
        .out_rem   (dv_rem[0]),
        .out_low   (dv_low[0]),
        .out_den   (dv_den[0]),
        .out_flags (dv_flags[0])
    );

    // One stage per quotient bit
    for (genvar i = 0; i < FRAC_BITS; i++)
    begin : g_div
        pwn_div_step #(
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[i]),
            .in_ready  (dv_ready[i]),
            .in_rem    (dv_rem[i]),
            .in_low    (dv_low[i]),
            .in_den    (dv_den[i]),
            .in_flags  (dv_flags[i]),
            .out_valid (dv_valid[i+1]),
            .out_ready (dv_ready[i+1]),
            .out_rem   (dv_rem[i+1]),
            .out_low   (dv_low[i+1]),
            .out_den   (dv_den[i+1]),
            .out_flags (dv_flags[i+1])
        );
    end

    pwn_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid[FRAC_BITS]),
        .in_ready  (dv_ready[FRAC_BITS]),
        .in_quot   (dv_low[FRAC_BITS]),
        .in_flags  (dv_flags[FRAC_BITS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_cmd   (m_tdata)
    );

`ifndef SYNTH
    // Partial remainder stays below the divisor on entry to the divider
    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid[0] && !dv_flags[0].zero && !dv_flags[0].sat
            |-> dv_rem[0] < dv_den[0])
        else $error("divider input remainder not below divisor");

    // Final remainder stays below the divisor
    a_rem_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid[FRAC_BITS] && !dv_flags[FRAC_BITS].zero && !dv_flags[FRAC_BITS].sat
            |-> dv_rem[FRAC_BITS] < dv_den[FRAC_BITS])
        else $error("divider output remainder not below divisor");

    // With the output register empty the whole chain must take a word
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");
`endif

endmodule

`default_nettype wire
